>>> design/elg_pkg.sv
// Shared types and constants for the exponential and linear gain envelope.
package elg_pkg;

    localparam int GAIN_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;

    // Operation carried by the func field of an input transaction.
    typedef enum logic [1:0] {
        FUNC_PROCESS = 2'd0,
        FUNC_SKIP    = 2'd1,
        FUNC_RESTART = 2'd2
    } func_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEP    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_GAIN   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_RAMP   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_GAIN,
        ST_P_ROUND,
        ST_P_LO,
        ST_P_HI,
        ST_P_ACC,
        ST_P_UPDATE,
        ST_P_OUT,
        ST_S_CHECK,
        ST_S_SQUARE,
        ST_S_BASE,
        ST_S_RAMP_MUL,
        ST_S_RAMP
    } state_t;

    // Operands handed to the shared multiplier.
    typedef struct packed {
        logic [GAIN_BITS-1:0] a;
        logic [GAIN_BITS-1:0] b;
    } mul_req_t;

endpackage

>>> design/elg_mul_unit.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
module elg_mul_unit (
    input  logic                           clk,
    input  elg_pkg::mul_req_t              req,
    output logic [2*elg_pkg::GAIN_BITS-1:0] prod
);
    import elg_pkg::*;

    logic [2*GAIN_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

>>> design/exp_linear_gain_envelope_unit.sv
// Top level of the exponential and linear gain envelope with its sequencer.
// A process transaction is accepted in the idle cycle and its result is valid in the
// same cycle in which the input is ready again, so no new transaction is accepted before
// the result is registered; an unaccepted result holds the sequencer in its last state.
// A skip runs S_CHECK, S_SQUARE for a set bit and S_BASE per bit of skip_count up to its
// highest set bit, then S_CHECK, S_RAMP_MUL and S_RAMP; a restart is taken in the idle cycle.
// Reset (rst_n, asynchronous, active low) loads the configuration reset values and gains.
module exp_linear_gain_envelope_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 30,
    parameter int SKIP_BITS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                add_mode,
    input  logic signed [SAMPLE_BITS-1:0]       accum_in,
    input  logic [SKIP_BITS-1:0]                skip_count,
    // Output channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic                                clipped,
    output logic [elg_pkg::GAIN_BITS-1:0]       gain_now,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [elg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [elg_pkg::GAIN_BITS-1:0]       cfg_data
);
    import elg_pkg::*;

    // The combined gain exp_gain * |ramp_gain| in Q format has C_BITS integer-plus-fraction
    // bits after rounding. The sample product then needs ACC_BITS bits before its final shift.
    localparam int PW       = 2 * GAIN_BITS;
    localparam int C_BITS   = PW - GAIN_FRAC_BITS;
    localparam int ACC_BITS = C_BITS + SAMPLE_BITS + 1;

    localparam logic [PW:0]       HALF_W = (PW + 1)'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [ACC_BITS-1:0] LIM_W = ACC_BITS'(1) << SAMPLE_BITS;
    localparam logic [GAIN_BITS-1:0] ONE_GAIN = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic signed [SAMPLE_BITS+1:0] S_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS+1:0] S_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [PW:0] R_MAX = 65'sd2147483647;
    localparam logic signed [PW:0] R_MIN = -65'sd2147483648;

    // Rounds a Q product to Q fraction bits, saturating to the unsigned 32-bit range.
    function automatic logic [GAIN_BITS-1:0] gain_round(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = ({1'b0, p} + HALF_W) >> GAIN_FRAC_BITS;
        if (|s[PW:GAIN_BITS])
            return '1;
        return s[GAIN_BITS-1:0];
    endfunction

    // Configuration and envelope state.
    logic [GAIN_BITS-1:0] decay_reg, step_reg, start_gain_reg, start_ramp_reg;
    logic [GAIN_BITS-1:0] exp_gain_reg, ramp_gain_reg;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    // Working registers of the current transaction.
    logic [GAIN_BITS-1:0]        mag_reg;       // |ramp_gain| for a process, |ramp_step| for a skip
    logic                        neg_reg;       // sign of the product to be applied
    logic [SAMPLE_BITS-1:0]      sm_reg;        // |sample_in|
    logic signed [SAMPLE_BITS-1:0] addend_reg;  // accum_in in add mode, otherwise zero
    logic [GAIN_BITS-1:0]        gain_hold_reg; // gain applied to this sample
    logic [C_BITS-1:0]           c_reg;         // rounded combined gain
    logic [ACC_BITS-1:0]         acc_reg;       // sample product plus rounding half
    logic [GAIN_BITS-1:0]        pow_reg, base_reg;
    logic [SKIP_BITS-1:0]        n_reg, cnt_reg;

    logic signed [SAMPLE_BITS-1:0] res_sample_reg, sample_out_reg;
    logic                          res_clip_reg, clipped_reg;
    logic [GAIN_BITS-1:0]          gain_out_reg;

    mul_req_t      mul_req;
    logic [PW-1:0] prod;

    elg_mul_unit u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    logic in_accept;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Sequencer: next state and the operands of the shared multiplier.
    always_comb
    begin
        state_next = state_reg;
        mul_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        FUNC_PROCESS: state_next = ST_P_GAIN;
                        FUNC_SKIP:    state_next = ST_S_CHECK;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_P_GAIN:
            begin
                mul_req.a  = exp_gain_reg;
                mul_req.b  = mag_reg;
                state_next = ST_P_ROUND;
            end
            ST_P_ROUND: state_next = ST_P_LO;
            ST_P_LO:
            begin
                mul_req.a  = c_reg[GAIN_BITS-1:0];
                mul_req.b  = GAIN_BITS'(sm_reg);
                state_next = ST_P_HI;
            end
            ST_P_HI:
            begin
                mul_req.a  = GAIN_BITS'(c_reg[C_BITS-1:GAIN_BITS]);
                mul_req.b  = GAIN_BITS'(sm_reg);
                state_next = ST_P_ACC;
            end
            ST_P_ACC:
            begin
                mul_req.a  = exp_gain_reg;
                mul_req.b  = decay_reg;
                state_next = ST_P_UPDATE;
            end
            ST_P_UPDATE: state_next = ST_P_OUT;
            ST_P_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            ST_S_CHECK:
            begin
                if (n_reg == '0)
                begin
                    mul_req.a  = exp_gain_reg;
                    mul_req.b  = pow_reg;
                    state_next = ST_S_RAMP_MUL;
                end
                else if (n_reg[0])
                begin
                    mul_req.a  = pow_reg;
                    mul_req.b  = base_reg;
                    state_next = ST_S_SQUARE;
                end
                else
                begin
                    mul_req.a  = base_reg;
                    mul_req.b  = base_reg;
                    state_next = ST_S_BASE;
                end
            end
            ST_S_SQUARE:
            begin
                mul_req.a  = base_reg;
                mul_req.b  = base_reg;
                state_next = ST_S_BASE;
            end
            ST_S_BASE: state_next = ST_S_CHECK;
            ST_S_RAMP_MUL:
            begin
                mul_req.a  = GAIN_BITS'(cnt_reg);
                mul_req.b  = mag_reg;
                state_next = ST_S_RAMP;
            end
            ST_S_RAMP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Final result of a process: shift out the fraction, clamp the magnitude, apply the
    // sign, add the accumulator sample and saturate to the sample range.
    logic [ACC_BITS-1:0]             mag_shift;
    logic [SAMPLE_BITS:0]            m_clamp;
    logic signed [SAMPLE_BITS+1:0]   prod_s, sum_s;
    logic signed [SAMPLE_BITS-1:0]   res_sample;
    logic                            res_clip;

    always_comb
    begin
        mag_shift = acc_reg >> GAIN_FRAC_BITS;
        m_clamp   = (mag_shift > LIM_W) ? LIM_W[SAMPLE_BITS:0] : mag_shift[SAMPLE_BITS:0];
        prod_s    = neg_reg ? -signed'({1'b0, m_clamp}) : signed'({1'b0, m_clamp});
        sum_s     = prod_s + {{2{addend_reg[SAMPLE_BITS-1]}}, addend_reg};
        res_clip  = 1'b0;
        res_sample = sum_s[SAMPLE_BITS-1:0];
        if (sum_s > S_MAX)
        begin
            res_sample = S_MAX[SAMPLE_BITS-1:0];
            res_clip   = 1'b1;
        end
        else if (sum_s < S_MIN)
        begin
            res_sample = S_MIN[SAMPLE_BITS-1:0];
            res_clip   = 1'b1;
        end
    end

    // Ramp updates: one step after a process, count steps after a skip.
    logic signed [GAIN_BITS:0] ramp_sum1;
    logic [GAIN_BITS-1:0]      ramp_step_sat;
    logic signed [PW:0]        ramp_delta, ramp_sum_n;
    logic [GAIN_BITS-1:0]      ramp_skip_sat;

    always_comb
    begin
        ramp_sum1 = signed'({ramp_gain_reg[GAIN_BITS-1], ramp_gain_reg})
                  + signed'({step_reg[GAIN_BITS-1], step_reg});
        if (ramp_sum1[GAIN_BITS] != ramp_sum1[GAIN_BITS-1])
            ramp_step_sat = {ramp_sum1[GAIN_BITS], {(GAIN_BITS-1){~ramp_sum1[GAIN_BITS]}}};
        else
            ramp_step_sat = ramp_sum1[GAIN_BITS-1:0];

        ramp_delta = neg_reg ? -signed'({1'b0, prod}) : signed'({1'b0, prod});
        ramp_sum_n = signed'({{(PW-GAIN_BITS+1){ramp_gain_reg[GAIN_BITS-1]}}, ramp_gain_reg})
                   + ramp_delta;
        if (ramp_sum_n > R_MAX)
            ramp_skip_sat = R_MAX[GAIN_BITS-1:0];
        else if (ramp_sum_n < R_MIN)
            ramp_skip_sat = R_MIN[GAIN_BITS-1:0];
        else
            ramp_skip_sat = ramp_sum_n[GAIN_BITS-1:0];
    end

    // Configuration, gains and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg      <= ONE_GAIN;
            step_reg       <= '0;
            start_gain_reg <= ONE_GAIN;
            start_ramp_reg <= ONE_GAIN;
            exp_gain_reg   <= ONE_GAIN;
            ramp_gain_reg  <= ONE_GAIN;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DECAY_FACTOR: decay_reg      <= cfg_data;
                    CFG_RAMP_STEP:    step_reg       <= cfg_data;
                    CFG_START_GAIN:   start_gain_reg <= cfg_data;
                    CFG_START_RAMP:   start_ramp_reg <= cfg_data;
                    default:          decay_reg      <= decay_reg;
                endcase
            end

            // A restart is taken in the idle cycle; every other update lands at the
            // end of its own sequencer step.
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && func == FUNC_RESTART)
                    begin
                        exp_gain_reg  <= start_gain_reg;
                        ramp_gain_reg <= start_ramp_reg;
                    end
                end
                ST_P_UPDATE:
                begin
                    exp_gain_reg  <= gain_round(prod);
                    ramp_gain_reg <= ramp_step_sat;
                end
                ST_S_RAMP_MUL: exp_gain_reg  <= gain_round(prod);
                ST_S_RAMP:     ramp_gain_reg <= ramp_skip_sat;
                default: ;
            endcase

            if (state_reg == ST_P_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            gain_hold_reg <= exp_gain_reg;
            sm_reg        <= sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
            addend_reg    <= add_mode ? accum_in : '0;
            n_reg         <= skip_count;
            cnt_reg       <= skip_count;
            pow_reg       <= ONE_GAIN;
            base_reg      <= decay_reg;
            if (func == FUNC_SKIP)
            begin
                mag_reg <= step_reg[GAIN_BITS-1] ? (~step_reg + 1'b1) : step_reg;
                neg_reg <= step_reg[GAIN_BITS-1];
            end
            else
            begin
                mag_reg <= ramp_gain_reg[GAIN_BITS-1] ? (~ramp_gain_reg + 1'b1)
                                                       : ramp_gain_reg;
                neg_reg <= sample_in[SAMPLE_BITS-1] ^ ramp_gain_reg[GAIN_BITS-1];
            end
        end

        case (state_reg)
            ST_P_ROUND:
            begin
                c_reg <= C_BITS'((prod + HALF_W[PW-1:0]) >> GAIN_FRAC_BITS);
            end
            ST_P_HI:  acc_reg <= ACC_BITS'(prod) + ACC_BITS'(HALF_W);
            ST_P_ACC: acc_reg <= acc_reg + {prod[ACC_BITS-GAIN_BITS-1:0], {GAIN_BITS{1'b0}}};
            ST_P_UPDATE:
            begin
                res_sample_reg <= res_sample;
                res_clip_reg   <= res_clip;
            end
            ST_S_SQUARE: pow_reg <= gain_round(prod);
            ST_S_BASE:
            begin
                base_reg <= gain_round(prod);
                n_reg    <= n_reg >> 1;
            end
            default: c_reg <= c_reg;
        endcase

        if (state_reg == ST_P_OUT && (!out_valid_reg || out_ready))
        begin
            sample_out_reg <= res_sample_reg;
            clipped_reg    <= res_clip_reg;
            gain_out_reg   <= gain_hold_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;
    assign gain_now   = gain_out_reg;

endmodule

>>> design/elg_checker.sv
// Port-level assertions for the gain envelope and the bind that attaches them.
module elg_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [1:0]                    func,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] sample_out,
    input logic                          clipped,
    input logic [elg_pkg::GAIN_BITS-1:0] gain_now
);
    import elg_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A stalled result transaction holds its sample and gain.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(gain_now))
        else $error("result changed while stalled");

    // An accepted process or skip transaction drops in_ready, since it occupies the sequencer.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_PROCESS || func == FUNC_SKIP) |=> !in_ready)
        else $error("input ready right after a multi-cycle transaction");

    // A saturated result sits at one end of the sample range.
    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> sample_out == S_MAX || sample_out == S_MIN)
        else $error("clipped flag without a saturated sample");

    // A new result only appears while the sequencer was busy finishing it.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the sequencer was idle");

endmodule

bind exp_linear_gain_envelope_unit elg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_elg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .gain_now   (gain_now)
);
